[rtl/core/csp_pkg.sv]
// capsule support point: shared types, register codes and fixed widths
// no dependencies; imported by every module of the block
package csp_pkg;

    localparam int COORD_W = 32;
    localparam int QUAT_W  = 16;
    localparam int SIZE_W  = 16;
    localparam int AXIS_W  = 34;
    localparam int HP_W    = SIZE_W + 1 + AXIS_W;
    localparam int SQ_W    = 64;
    localparam int ROOT_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [63:0] QUAT_RESET = 64'h4000_0000_0000_0000;
    localparam logic [31:0] SIZE_RESET = 32'h0000_0100;
    localparam logic signed [AXIS_W-1:0] AXIS_ONE = 34'sh1000_0000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_X = 3'd0,
        CFG_POS_Y = 3'd1,
        CFG_POS_Z = 3'd2,
        CFG_QUAT  = 3'd3,
        CFG_SIZE  = 3'd4
    } t_cfg_idx;

    // per item control flags carried down the pipeline
    typedef struct packed {
        logic       op;
        logic       zero;
        logic       pick_b;
        logic [2:0] neg;
    } t_flags;

    // one result item
    typedef struct packed {
        logic [COORD_W-1:0] pt_x;
        logic [COORD_W-1:0] pt_y;
        logic [COORD_W-1:0] pt_z;
        logic               end_sel;
        logic               zero_dir;
        logic               saturated;
    } t_result;

endpackage

[rtl/core/csp_isqrt.sv]
// pipelined floor square root, one result bit per stage, side data carried along
// depends on csp_pkg
module csp_isqrt #(
    parameter int SIDE_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [csp_pkg::SQ_W-1:0]    i_sq,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_vld,
    output logic [csp_pkg::ROOT_W-1:0]  o_root,
    output logic [SIDE_W-1:0]           o_side
);
    import csp_pkg::*;

    localparam int TW = SQ_W + 2;

    logic              r_vld  [ROOT_W+1];
    logic [SQ_W-1:0]   r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_root [ROOT_W+1];
    logic [SIDE_W-1:0] r_side [ROOT_W+1];

    assign r_vld[0]  = i_vld;
    assign r_rem[0]  = i_sq;
    assign r_root[0] = '0;
    assign r_side[0] = i_side;

    // one root bit per stage, most significant first
    for (genvar j = 0; j < ROOT_W; j++) begin : g_step
        localparam int B = ROOT_W - 1 - j;
        logic [TW-1:0]     w_trial;
        logic              w_ge;
        logic [SQ_W-1:0]   n_rem;
        logic [ROOT_W-1:0] n_root;

        always_comb begin
            w_trial = (TW'(r_root[j]) << (B + 1)) + (TW'(1) << (2 * B));
            w_ge    = TW'(r_rem[j]) >= w_trial;
            n_rem   = w_ge ? (r_rem[j] - w_trial[SQ_W-1:0]) : r_rem[j];
            n_root  = w_ge ? (r_root[j] | (ROOT_W'(1) << B)) : r_root[j];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
            if (i_en) begin
                r_rem[j+1]  <= n_rem;
                r_root[j+1] <= n_root;
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W];
    assign o_root = r_root[ROOT_W];
    assign o_side = r_side[ROOT_W];

endmodule

[rtl/core/csp_div.sv]
// pipelined rounding divider, three lanes sharing one divisor, one quotient bit per stage
// depends on csp_pkg
module csp_div #(
    parameter int NW     = 56,
    parameter int QW     = 27,
    parameter int SIDE_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [NW-1:0]               i_num [3],
    input  logic [csp_pkg::ROOT_W-1:0]  i_len,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_vld,
    output logic [QW-1:0]               o_quo [3],
    output logic [SIDE_W-1:0]           o_side
);
    import csp_pkg::*;

    localparam int DW = NW + 1;

    logic              r_vld  [QW+1];
    logic [DW-1:0]     r_rem  [QW+1][3];
    logic [QW-1:0]     r_quo  [QW+1][3];
    logic [ROOT_W-1:0] r_dvs  [QW+1];
    logic [SIDE_W-1:0] r_side [QW+1];

    // first stage adds half the divisor for round half up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= DW'(i_num[l]) + DW'(i_len >> 1);
                r_quo[0][l] <= '0;
            end
            r_dvs[0]  <= i_len;
            r_side[0] <= i_side;
        end
    end

    // restoring steps, most significant quotient bit first
    for (genvar j = 0; j < QW; j++) begin : g_step
        localparam int B = QW - 1 - j;
        logic [DW:0] w_trial;

        assign w_trial = {(DW + 1 - ROOT_W)'(0), r_dvs[j]} << B;

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic          w_ge;
            logic [DW-1:0] n_rem;
            logic [QW-1:0] n_quo;

            always_comb begin
                w_ge  = {1'b0, r_rem[j][l]} >= w_trial;
                n_rem = w_ge ? (r_rem[j][l] - w_trial[DW-1:0]) : r_rem[j][l];
                n_quo = w_ge ? (r_quo[j][l] | (QW'(1) << B)) : r_quo[j][l];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j+1][l] <= n_rem;
                    r_quo[j+1][l] <= n_quo;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
            if (i_en) begin
                r_dvs[j+1]  <= r_dvs[j];
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_vld  = r_vld[QW];
    assign o_quo  = r_quo[QW];
    assign o_side = r_side[QW];

endmodule

[rtl/core/capsule_support_point_top.sv]
// capsule support point: front stages, endpoint choice, output register and skid
// depends on csp_pkg, csp_isqrt and csp_div
//
// Usage
//   Configuration: write pos_x/pos_y/pos_z, quat_packed and shape_size through
//   i_cfg_we / i_cfg_idx / i_cfg_data while no item is in flight.
//   Input channel: i_valid with op and direction; the item is taken at a clock
//   edge where i_valid is high and o_stall is low.
//   Output channel: o_valid with the support point and flags; the item is taken
//   at an edge where o_valid is high and i_stall is low.
//   Throughput: one item per cycle while o_stall is low. From acceptance to
//   o_valid an item passes through eight front stages, the 32 stage square
//   root, and the divider with one stage per quotient bit
//   (COORD_FRAC_BITS + 11, 27 for Q16.16) plus its rounding stage, then the output register.
//   Stall: a result held by the receiver sits in the output register and the
//   next one lands in a skid register; only then does o_stall rise and the
//   whole pipeline hold. No item is dropped or repeated.
//   Reset: synchronous, active low; empties the pipeline, sets the centre to
//   zero, the quaternion to identity, radius 1.0 and half length 0.
module capsule_support_point_top #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [csp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [csp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_op,
    input  logic signed [31:0]              i_dir_x,
    input  logic signed [31:0]              i_dir_y,
    input  logic signed [31:0]              i_dir_z,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [31:0]              o_pt_x,
    output logic signed [31:0]              o_pt_y,
    output logic signed [31:0]              o_pt_z,
    output logic                            o_end_sel,
    output logic                            o_zero_dir,
    output logic                            o_saturated
);
    import csp_pkg::*;

    localparam int SH  = 36 - COORD_FRAC_BITS;
    localparam int OW  = HP_W - SH;
    localparam int OH  = OW - 16;
    localparam int PHW = OH + COORD_W;
    localparam int SHW = PHW + 2;
    localparam int PLW = 17 + COORD_W;
    localparam int SLW = PLW + 2;
    localparam int TW  = SHW + 17;
    localparam int PTW = (OW > COORD_W ? OW : COORD_W) + 2;
    localparam int RMW = SIZE_W + COORD_W;
    localparam int NW  = RMW + COORD_FRAC_BITS - 8;
    localparam int QW  = NW + 1 - 30;
    localparam int FW  = $bits(t_flags);
    localparam int SIDE1_W = FW + 3 * PTW + 3 * NW;
    localparam int SIDE2_W = FW + 3 * PTW;
    localparam logic signed [HP_W-1:0] HP_RND = HP_W'(1) << (SH - 1);
    localparam logic signed [PTW:0] SAT_HI = (PTW + 1)'(33'sh0_7FFF_FFFF);
    localparam logic signed [PTW:0] SAT_LO = -$signed((PTW + 1)'(32'h8000_0000));

    // shift that brings a nonzero largest magnitude into [2^30, 2^32)
    function automatic logic [4:0] f_norm_shift(input logic [31:0] v);
        logic [4:0] p;
        p = '0;
        for (int b = 0; b < 32; b++) begin
            if (v[b]) p = 5'(b);
        end
        return (v[31] | v[30]) ? 5'd0 : 5'(30 - int'(p));
    endfunction

    logic               w_en;

    // configuration registers
    logic signed [31:0] r_pos [3];
    logic [63:0]        r_quat;
    logic [31:0]        r_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos[0] <= '0;
            r_pos[1] <= '0;
            r_pos[2] <= '0;
            r_quat   <= QUAT_RESET;
            r_size   <= SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POS_X: r_pos[0] <= i_cfg_data[31:0];
                CFG_POS_Y: r_pos[1] <= i_cfg_data[31:0];
                CFG_POS_Z: r_pos[2] <= i_cfg_data[31:0];
                CFG_QUAT:  r_quat   <= i_cfg_data;
                CFG_SIZE:  r_size   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic signed [QUAT_W-1:0] w_qw, w_qx, w_qy, w_qz;
    logic [SIZE_W-1:0]        w_radius, w_half;
    assign w_qw     = r_quat[63:48];
    assign w_qx     = r_quat[47:32];
    assign w_qy     = r_quat[31:16];
    assign w_qz     = r_quat[15:0];
    assign w_radius = r_size[15:0];
    assign w_half   = r_size[31:16];

    // stage a: capture item, magnitudes, quaternion products
    logic               r_a_vld, r_a_op, r_a_zero;
    logic signed [31:0] r_a_d [3];
    logic [31:0]        r_a_m [3];
    logic signed [31:0] r_a_xz, r_a_wy, r_a_yz, r_a_wx, r_a_xx, r_a_yy;
    logic signed [31:0] w_dir [3];

    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_valid;
        end
        if (w_en) begin
            r_a_op   <= i_op;
            r_a_zero <= (i_dir_x == '0) && (i_dir_y == '0) && (i_dir_z == '0);
            for (int l = 0; l < 3; l++) begin
                r_a_d[l] <= w_dir[l];
                r_a_m[l] <= w_dir[l][31] ? (~w_dir[l] + 32'd1) : w_dir[l];
            end
            r_a_xz <= w_qx * w_qz;
            r_a_wy <= w_qw * w_qy;
            r_a_yz <= w_qy * w_qz;
            r_a_wx <= w_qw * w_qx;
            r_a_xx <= w_qx * w_qx;
            r_a_yy <= w_qy * w_qy;
        end
    end

    // stage b: segment axis, largest magnitude
    logic                     r_b_vld, r_b_op, r_b_zero;
    logic signed [31:0]       r_b_d [3];
    logic [31:0]              r_b_m [3];
    logic [31:0]              r_b_mx;
    logic signed [AXIS_W-1:0] r_b_axis [3];
    logic [31:0]              w_mx01;

    assign w_mx01 = (r_a_m[0] > r_a_m[1]) ? r_a_m[0] : r_a_m[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
        if (w_en) begin
            r_b_op   <= r_a_op;
            r_b_zero <= r_a_zero;
            r_b_d    <= r_a_d;
            r_b_m    <= r_a_m;
            r_b_mx   <= (r_a_m[2] > w_mx01) ? r_a_m[2] : w_mx01;
            r_b_axis[0] <= (AXIS_W'(r_a_xz) + AXIS_W'(r_a_wy)) <<< 1;
            r_b_axis[1] <= (AXIS_W'(r_a_yz) - AXIS_W'(r_a_wx)) <<< 1;
            r_b_axis[2] <= AXIS_ONE - ((AXIS_W'(r_a_xx) + AXIS_W'(r_a_yy)) <<< 1);
        end
    end

    // stage c: half length times axis, normalising shift
    logic                   r_c_vld, r_c_op, r_c_zero;
    logic signed [31:0]     r_c_d [3];
    logic [31:0]            r_c_m [3];
    logic [4:0]             r_c_k;
    logic signed [HP_W-1:0] r_c_hp [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_b_vld;
        end
        if (w_en) begin
            r_c_op   <= r_b_op;
            r_c_zero <= r_b_zero;
            r_c_d    <= r_b_d;
            r_c_m    <= r_b_m;
            r_c_k    <= f_norm_shift(r_b_mx);
            for (int l = 0; l < 3; l++) begin
                r_c_hp[l] <= $signed({1'b0, w_half}) * r_b_axis[l];
            end
        end
    end

    // stage d: offset rounded to coordinate format, normalised magnitudes
    logic                 r_d_vld, r_d_op, r_d_zero;
    logic signed [31:0]   r_d_d [3];
    logic [31:0]          r_d_mn [3];
    logic signed [OW-1:0] r_d_off [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_en) begin
            r_d_vld <= r_c_vld;
        end
        if (w_en) begin
            r_d_op   <= r_c_op;
            r_d_zero <= r_c_zero;
            r_d_d    <= r_c_d;
            for (int l = 0; l < 3; l++) begin
                r_d_mn[l]  <= r_c_m[l] << r_c_k;
                r_d_off[l] <= OW'((r_c_hp[l] + HP_RND) >>> SH);
            end
        end
    end

    // stage e: split dot products, squares, radius products
    logic                  r_e_vld, r_e_op, r_e_zero;
    logic [2:0]            r_e_neg;
    logic signed [OW-1:0]  r_e_off [3];
    logic signed [PHW-1:0] r_e_ph [3];
    logic signed [PLW-1:0] r_e_pl [3];
    logic [SQ_W-1:0]       r_e_sq [3];
    logic [RMW-1:0]        r_e_rm [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_en) begin
            r_e_vld <= r_d_vld;
        end
        if (w_en) begin
            r_e_op   <= r_d_op;
            r_e_zero <= r_d_zero;
            r_e_off  <= r_d_off;
            for (int l = 0; l < 3; l++) begin
                r_e_neg[l] <= r_d_d[l][31];
                r_e_ph[l]  <= $signed(r_d_off[l][OW-1:16]) * r_d_d[l];
                r_e_pl[l]  <= $signed({1'b0, r_d_off[l][15:0]}) * r_d_d[l];
                r_e_sq[l]  <= r_d_mn[l] * r_d_mn[l];
                r_e_rm[l]  <= w_radius * r_d_mn[l];
            end
        end
    end

    // stage f: partial dot sums, sum of squares, scaled numerators
    logic                  r_f_vld, r_f_op, r_f_zero;
    logic [2:0]            r_f_neg;
    logic signed [OW-1:0]  r_f_off [3];
    logic signed [SHW-1:0] r_f_sh;
    logic signed [SLW-1:0] r_f_sl;
    logic [SQ_W-1:0]       r_f_sq;
    logic [NW-1:0]         r_f_num [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= r_e_vld;
        end
        if (w_en) begin
            r_f_op   <= r_e_op;
            r_f_zero <= r_e_zero;
            r_f_neg  <= r_e_neg;
            r_f_off  <= r_e_off;
            r_f_sh   <= SHW'(r_e_ph[0]) + SHW'(r_e_ph[1]) + SHW'(r_e_ph[2]);
            r_f_sl   <= SLW'(r_e_pl[0]) + SLW'(r_e_pl[1]) + SLW'(r_e_pl[2]);
            r_f_sq   <= r_e_sq[0] + r_e_sq[1] + r_e_sq[2];
            for (int l = 0; l < 3; l++) begin
                r_f_num[l] <= NW'(r_e_rm[l]) << (COORD_FRAC_BITS - 8);
            end
        end
    end

    // stage g: exact sign of the dot product picks the endpoint
    logic                 r_g_vld;
    t_flags               r_g_flags;
    logic signed [OW-1:0] r_g_off [3];
    logic [SQ_W-1:0]      r_g_sq;
    logic [NW-1:0]        r_g_num [3];
    logic signed [TW-1:0] w_tot;

    assign w_tot = (TW'(r_f_sh) <<< 16) + TW'(r_f_sl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (w_en) begin
            r_g_vld <= r_f_vld;
        end
        if (w_en) begin
            r_g_flags.op     <= r_f_op;
            r_g_flags.zero   <= r_f_zero;
            r_g_flags.pick_b <= !r_f_zero && (w_tot > 0);
            r_g_flags.neg    <= r_f_neg;
            r_g_off <= r_f_off;
            r_g_sq  <= r_f_sq;
            r_g_num <= r_f_num;
        end
    end

    // stage h: endpoint from centre and offset
    logic                  r_h_vld;
    t_flags                r_h_flags;
    logic signed [PTW-1:0] r_h_pt [3];
    logic [SQ_W-1:0]       r_h_sq;
    logic [NW-1:0]         r_h_num [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (w_en) begin
            r_h_vld <= r_g_vld;
        end
        if (w_en) begin
            r_h_flags <= r_g_flags;
            r_h_sq    <= r_g_sq;
            r_h_num   <= r_g_num;
            for (int l = 0; l < 3; l++) begin
                r_h_pt[l] <= r_g_flags.pick_b ? (PTW'(r_pos[l]) + PTW'(r_g_off[l]))
                                              : (PTW'(r_pos[l]) - PTW'(r_g_off[l]));
            end
        end
    end

    // direction length
    logic [SIDE1_W-1:0] w_side1_in, w_side1_out;
    logic               w_sq_vld;
    logic [ROOT_W-1:0]  w_len;
    t_flags             w_s_flags;
    logic [PTW-1:0]     w_s_pt [3];
    logic [NW-1:0]      w_s_num [3];

    assign w_side1_in = {r_h_flags, r_h_pt[0], r_h_pt[1], r_h_pt[2],
                         r_h_num[0], r_h_num[1], r_h_num[2]};
    assign {w_s_flags, w_s_pt[0], w_s_pt[1], w_s_pt[2],
            w_s_num[0], w_s_num[1], w_s_num[2]} = w_side1_out;

    csp_isqrt #(
        .SIDE_W (SIDE1_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_h_vld),
        .i_sq    (r_h_sq),
        .i_side  (w_side1_in),
        .o_vld   (w_sq_vld),
        .o_root  (w_len),
        .o_side  (w_side1_out)
    );

    // radius offset components
    logic [SIDE2_W-1:0] w_side2_in, w_side2_out;
    logic               w_res_vld;
    logic [QW-1:0]      w_quo [3];
    t_flags             w_r_flags;
    logic [PTW-1:0]     w_r_pt [3];

    assign w_side2_in = {w_s_flags, w_s_pt[0], w_s_pt[1], w_s_pt[2]};
    assign {w_r_flags, w_r_pt[0], w_r_pt[1], w_r_pt[2]} = w_side2_out;

    csp_div #(
        .NW     (NW),
        .QW     (QW),
        .SIDE_W (SIDE2_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_num   (w_s_num),
        .i_len   (w_len),
        .i_side  (w_side2_in),
        .o_vld   (w_res_vld),
        .o_quo   (w_quo),
        .o_side  (w_side2_out)
    );

    // final sum and saturation
    t_result              w_res;
    logic signed [PTW:0]  w_sum [3];
    logic [2:0]           w_clip;
    logic [COORD_W-1:0]   w_pt [3];
    logic                 w_add_r;

    always_comb begin
        w_add_r = !w_r_flags.op && !w_r_flags.zero;
        for (int l = 0; l < 3; l++) begin
            w_sum[l] = (PTW + 1)'($signed(w_r_pt[l]));
            if (w_add_r) begin
                w_sum[l] = w_r_flags.neg[l] ? (w_sum[l] - (PTW + 1)'(w_quo[l]))
                                            : (w_sum[l] + (PTW + 1)'(w_quo[l]));
            end
            w_clip[l] = 1'b1;
            if (w_sum[l] > SAT_HI) begin
                w_pt[l] = SAT_HI[COORD_W-1:0];
            end else if (w_sum[l] < SAT_LO) begin
                w_pt[l] = SAT_LO[COORD_W-1:0];
            end else begin
                w_pt[l]   = w_sum[l][COORD_W-1:0];
                w_clip[l] = 1'b0;
            end
        end
        w_res.pt_x      = w_pt[0];
        w_res.pt_y      = w_pt[1];
        w_res.pt_z      = w_pt[2];
        w_res.end_sel   = w_r_flags.pick_b;
        w_res.zero_dir  = w_r_flags.zero;
        w_res.saturated = |w_clip;
    end

    // output register with skid stage
    logic    r_out_vld, r_skid_vld, w_free;
    t_result r_out, r_skid;

    assign w_free = !r_out_vld || !i_stall;
    assign w_en   = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_free) begin
                r_out      <= r_skid;
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (w_res_vld) begin
            if (w_free) begin
                r_out     <= w_res;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= w_res;
                r_skid_vld <= 1'b1;
            end
        end else if (w_free) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_stall     = r_skid_vld;
    assign o_valid     = r_out_vld;
    assign o_pt_x      = r_out.pt_x;
    assign o_pt_y      = r_out.pt_y;
    assign o_pt_z      = r_out.pt_z;
    assign o_end_sel   = r_out.end_sel;
    assign o_zero_dir  = r_out.zero_dir;
    assign o_saturated = r_out.saturated;

`ifndef SYNTH
    // skid holds an item only behind a held output item
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid item without output item");

    // skid fills only when the output item was held
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && i_stall))
        else $error("skid filled without a held output");

    // a zero direction never picks endpoint b
    a_zero_keeps_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_zero_dir && o_end_sel))
        else $error("zero direction picked endpoint b");

    // skid item stays unchanged while it waits behind a held output
    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && i_stall |=> r_skid_vld && $stable(r_skid))
        else $error("skid item changed while held");
`endif

endmodule
